// ----- src/box_filter_3x3_macros.svh -----
// Assertion macros used by the box filter checker.
// Needs nothing else; the caller supplies clock and reset names.
`ifndef BOX_FILTER_3X3_MACROS_SVH
`define BOX_FILTER_3X3_MACROS_SVH

// Implication checked on the following cycle, off while reset is high.
`define BF3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold on the cycle right after reset is seen.
`define BF3_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ----- src/bf3_pkg.sv -----
// Shared constants, types and register codes for the 3x3 box filter.
// No dependencies.
`timescale 1ns / 1ps

package bf3_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_HEIGHT     = 1024;
   localparam int PIXEL_BITS     = 16;

   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int ROW_BITS       = $clog2(MAX_HEIGHT) + 1;
   localparam int POS_BITS       = 10;
   localparam int CSR_DATA_BITS  = 11;

   localparam int WIDTH_RESET    = 640;
   localparam int HEIGHT_RESET   = 480;

   // column sum of three pixels, full sum of nine
   localparam int COLSUM_BITS    = PIXEL_BITS + 2;
   localparam int SUM_BITS       = PIXEL_BITS + 4;
   localparam int MAG_BITS       = SUM_BITS - 1;

   // floor(x/9) == (x * RECIP) >> RECIP_SHIFT for every x below 2**MAG_BITS
   localparam int    RECIP_SHIFT = MAG_BITS + 3;
   localparam longint RECIP      = (longint'(1) << RECIP_SHIFT) / 9 + 1;
   localparam int    PROD_BITS   = 2 * MAG_BITS;

   localparam int FIFO_DEPTH     = 8;
   localparam int PTR_BITS       = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS       = PTR_BITS + 1;

   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_FLUSH = 1'b1
   } command_type;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] sum;
      logic [POS_BITS-1:0]        row;
      logic [POS_BITS-1:0]        col;
      logic                       last;
   } res_entry_type;

   typedef struct packed {
      logic [1:0]    count;
      res_entry_type first;
      res_entry_type second;
   } res_push_type;

   typedef struct packed {
      logic [CNT_BITS-1:0] count;
      logic                not_empty;
   } fifo_status_type;

endpackage

// ----- src/bf3_chan_if.sv -----
// Valid/ready channels of the box filter: pixel requests and mean results.
// Depends on bf3_pkg.
`timescale 1ns / 1ps

interface bf3_req_if import bf3_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic signed [PIXEL_BITS-1:0] pixel_value;

   modport source (output valid, output command, output pixel_value, input ready);
   modport sink   (input valid, input command, input pixel_value, output ready);
endinterface

interface bf3_rsp_if import bf3_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [PIXEL_BITS-1:0] mean_value;
   logic [POS_BITS-1:0]          out_row;
   logic [POS_BITS-1:0]          out_column;
   logic                         last_of_run;

   modport source (output valid, output mean_value, output out_row, output out_column,
                   output last_of_run, input ready);
   modport sink   (input valid, input mean_value, input out_row, input out_column,
                   input last_of_run, output ready);
endinterface

// ----- src/bf3_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Read-first: a read of the address written in the same cycle gives old data.
`timescale 1ns / 1ps

module bf3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/bf3_res_fifo.sv -----
// Result queue: takes up to two entries per cycle, gives one per cycle.
// Depends on bf3_pkg.
`timescale 1ns / 1ps

module bf3_res_fifo import bf3_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  res_push_type    push,
   input  logic            pop,
   output res_entry_type   head,
   output fifo_status_type status
);

   res_entry_type       mem_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_nx;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_nx = wr_ptr_ff + PTR_BITS'(1);
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_nx] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head             = mem_ff[rd_ptr_ff];
   assign status.count     = count_ff;
   assign status.not_empty = (count_ff != '0);

endmodule

// ----- src/box_filter_3x3.sv -----
// 3x3 box filter, zero padded: one pixel per clock in raster order, one mean per
// centre pixel out. Sustained rate is one item per cycle while req ready is high;
// a result leaves after the item that completes its window, through the window
// update, the sums into the result queue and the divide by 9 into the output
// register. The item at the end of a row gives two results, so the 8-entry
// result queue absorbs that and lowers req ready only when it has no room for
// the results in flight. Two 1024 x 16 line memories hold the previous two rows;
// a write and the next read of the same column go through a bypass. Send one row
// of flush items after the image to drain the last row. Write the size registers
// only while idle. Depends on bf3_pkg, bf3_chan_if, bf3_ram and bf3_res_fifo.
`timescale 1ns / 1ps

module box_filter_3x3 import bf3_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   bf3_req_if.sink                  req_ch,
   bf3_rsp_if.source                rsp_ch
);

   // size registers, kept already clamped
   logic [COL_BITS-1:0]  wlast_ff;
   logic [ROW_BITS-1:0]  height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff  <= COL_BITS'(WIDTH_RESET - 1);
         height_ff <= ROW_BITS'(HEIGHT_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               if (csr_wdata == '0) begin
                  wlast_ff <= '0;
               end else if (int'(csr_wdata) > MAX_WIDTH) begin
                  wlast_ff <= COL_BITS'(MAX_WIDTH - 1);
               end else begin
                  wlast_ff <= COL_BITS'(csr_wdata - CSR_DATA_BITS'(1));
               end
            end
            CSR_IMAGE_HEIGHT: begin
               if (csr_wdata == '0) begin
                  height_ff <= ROW_BITS'(1);
               end else if (int'(csr_wdata) > MAX_HEIGHT) begin
                  height_ff <= ROW_BITS'(MAX_HEIGHT);
               end else begin
                  height_ff <= ROW_BITS'(csr_wdata);
               end
            end
         endcase
      end
   end

   // ---------------- accept stage ----------------
   logic                          req_acc;
   logic [COL_BITS-1:0]           col_ff, col_in, rd_addr;
   logic [ROW_BITS-1:0]           row_ff, row_in;
   logic                          flush_row, row_end, has_res;
   logic signed [PIXEL_BITS-1:0]  pix, top_px, mid_px, top_raw, mid_raw;
   logic [PIXEL_BITS-1:0]         above_q, two_above_q;
   logic                          byp_v_ff;
   logic signed [PIXEL_BITS-1:0]  above_byp_ff, two_byp_ff;
   logic signed [COLSUM_BITS-1:0] colsum_new;
   logic signed [COLSUM_BITS-1:0] cs_ff [3];

   // result stage bookkeeping
   logic                s1_full_ff, s1_edge_ff;
   logic [POS_BITS-1:0] s1_row_ff, s1_col_ff, s1_wlast_ff;
   logic [1:0]          s1_n;
   fifo_status_type     fifo_stat;

   assign s1_n = {1'b0, s1_full_ff} + {1'b0, s1_edge_ff};

   assign req_ch.ready = !reset &&
      ((int'(fifo_stat.count) + int'(s1_n) + 2) <= FIFO_DEPTH);
   assign req_acc = req_ch.valid && req_ch.ready;

   always_comb begin
      flush_row = (row_ff >= height_ff);
      row_end   = (col_ff >= wlast_ff);
      has_res   = (row_ff != '0);
      pix       = (!flush_row && req_ch.command == CMD_PIXEL) ? req_ch.pixel_value : '0;
      mid_raw   = byp_v_ff ? above_byp_ff : $signed(above_q);
      top_raw   = byp_v_ff ? two_byp_ff : $signed(two_above_q);
      // rows above the image read as zero whatever the buffers hold
      mid_px    = (row_ff >= ROW_BITS'(1)) ? mid_raw : '0;
      top_px    = (row_ff >= ROW_BITS'(2)) ? top_raw : '0;
      colsum_new = COLSUM_BITS'(top_px) + COLSUM_BITS'(mid_px) + COLSUM_BITS'(pix);

      col_in = col_ff;
      row_in = row_ff;
      if (req_acc) begin
         if (row_end) begin
            col_in = '0;
            row_in = flush_row ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
      // read ahead for the column of the next item
      rd_addr = reset ? '0 : col_in;
   end

   bf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_above (
      .clock   (clock),
      .wr_en   (req_acc),
      .wr_addr (col_ff),
      .wr_data (pix),
      .rd_addr (rd_addr),
      .rd_data (above_q)
   );

   bf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_two_above (
      .clock   (clock),
      .wr_en   (req_acc),
      .wr_addr (col_ff),
      .wr_data (mid_raw),
      .rd_addr (rd_addr),
      .rd_data (two_above_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         byp_v_ff   <= 1'b0;
         s1_full_ff <= 1'b0;
         s1_edge_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         // one-column rows read back the entry written this cycle
         byp_v_ff   <= req_acc && (col_in == col_ff);
         s1_full_ff <= req_acc && has_res && (col_ff != '0);
         s1_edge_ff <= req_acc && has_res && row_end;
      end
   end

   always_ff @(posedge clock) begin
      above_byp_ff <= pix;
      two_byp_ff   <= mid_raw;
      if (req_acc) begin
         cs_ff[0]    <= (col_ff == '0) ? '0 : cs_ff[1];
         cs_ff[1]    <= (col_ff == '0) ? '0 : cs_ff[2];
         cs_ff[2]    <= colsum_new;
         s1_row_ff   <= POS_BITS'(row_ff - ROW_BITS'(1));
         s1_col_ff   <= POS_BITS'(col_ff - COL_BITS'(1));
         s1_wlast_ff <= POS_BITS'(wlast_ff);
      end
   end

   // ---------------- sum stage: always moves, room reserved at accept ----------------
   res_push_type push;
   res_entry_type full_ent, edge_ent;

   always_comb begin
      full_ent.sum  = SUM_BITS'(cs_ff[0]) + SUM_BITS'(cs_ff[1]) + SUM_BITS'(cs_ff[2]);
      full_ent.row  = s1_row_ff;
      full_ent.col  = s1_col_ff;
      full_ent.last = !s1_edge_ff;
      edge_ent.sum  = SUM_BITS'(cs_ff[1]) + SUM_BITS'(cs_ff[2]);
      edge_ent.row  = s1_row_ff;
      edge_ent.col  = s1_wlast_ff;
      edge_ent.last = 1'b1;
      push.count    = s1_n;
      push.first    = s1_full_ff ? full_ent : edge_ent;
      push.second   = edge_ent;
   end

   res_entry_type head;
   logic          pop;

   bf3_res_fifo u_res_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (fifo_stat)
   );

   // ---------------- divide by 9 into the output register ----------------
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [PIXEL_BITS-1:0] mean_ff, mean_in, quot;
   logic [POS_BITS-1:0]          out_row_ff, out_col_ff;
   logic                         out_last_ff;
   logic signed [SUM_BITS-1:0]   head_sum;
   logic                         neg;
   logic [MAG_BITS-1:0]          mag, recip;
   logic [PROD_BITS-1:0]         prod;

   always_comb begin
      pop      = fifo_stat.not_empty && (!rsp_valid_ff || rsp_ch.ready);
      head_sum = $signed(head.sum);
      neg      = head_sum[SUM_BITS-1];
      mag      = MAG_BITS'(neg ? -head_sum : head_sum);
      recip    = MAG_BITS'(RECIP);
      prod     = PROD_BITS'(mag) * PROD_BITS'(recip);
      quot     = PIXEL_BITS'(prod >> RECIP_SHIFT);
      // truncation toward zero
      mean_in  = neg ? -quot : quot;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         mean_ff     <= mean_in;
         out_row_ff  <= head.row;
         out_col_ff  <= head.col;
         out_last_ff <= head.last;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.mean_value  = mean_ff;
   assign rsp_ch.out_row     = out_row_ff;
   assign rsp_ch.out_column  = out_col_ff;
   assign rsp_ch.last_of_run = out_last_ff;

endmodule

// ----- src/bf3_checker.sv -----
// Port-level checks on the box filter result channel, bound to the top level.
// Depends on bf3_pkg and box_filter_3x3_macros.svh.
`timescale 1ns / 1ps
`include "box_filter_3x3_macros.svh"

module bf3_checker import bf3_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_last,
   input logic [POS_BITS-1:0] rsp_row
);

   `BF3_ASSERT_AFTER_RESET(a_no_rsp_after_reset, clock, reset, !rsp_valid, "rsp valid after reset")

   `BF3_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped")

   // the second result of a row-end item is queued with the first
   `BF3_ASSERT_NEXT(a_pair_follows, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid, "pair broken")

   `BF3_ASSERT_NEXT(a_pair_same_row, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_row == $past(rsp_row), "pair row differs")

endmodule

bind box_filter_3x3 bf3_checker u_bf3_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_last  (rsp_ch.last_of_run),
   .rsp_row   (rsp_ch.out_row)
);
